// File: hw/rtl/beacon_sync_trigger_controller_core_macros.svh
// ---------------------------------------------------------------------------
// beacon sync trigger controller assertion macros
// shared concurrent assertion forms for the controller rtl
// ---------------------------------------------------------------------------
`ifndef BEACON_SYNC_TRIGGER_CONTROLLER_CORE_MACROS_SVH
`define BEACON_SYNC_TRIGGER_CONTROLLER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define BSTC_ASSERT_NOW(lbl, clk_s, rstn_s, pre, post) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (pre) |-> (post)) \
    else $error("bstc assertion failed");

// next-cycle implication
`define BSTC_ASSERT_NEXT(lbl, clk_s, rstn_s, pre, post) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (pre) |=> (post)) \
    else $error("bstc assertion failed");

`else

`define BSTC_ASSERT_NOW(lbl, clk_s, rstn_s, pre, post)
`define BSTC_ASSERT_NEXT(lbl, clk_s, rstn_s, pre, post)

`endif

`endif

// File: hw/rtl/bstc_pkg.sv
// ---------------------------------------------------------------------------
// bstc_pkg
// types and fixed constants of the beacon sync trigger controller
// ---------------------------------------------------------------------------
package bstc_pkg;

  localparam int CHAR_W = 8;
  typedef logic [CHAR_W-1:0] char_t;

  // trigger string registers: two 64-bit words of 8 characters each
  localparam int TRIG_WORD_W     = 64;
  localparam int TRIG_WORD_CHARS = TRIG_WORD_W / CHAR_W;
  localparam int TRIG_REG_CHARS  = 2 * TRIG_WORD_CHARS;

  localparam char_t CH_CR = 8'd13;

  // mode codes
  localparam int MODE_W = 3;
  typedef logic [MODE_W-1:0] mode_t;
  localparam mode_t M_IDLE         = 3'd0;
  localparam mode_t M_MAYBE_SYNC   = 3'd1;
  localparam mode_t M_SYNC         = 3'd2;
  localparam mode_t M_MAYBE_UNSYNC = 3'd3;
  localparam mode_t M_TX           = 3'd4;

  // saturating frame counter
  localparam int CNT_W = 6;
  typedef logic [CNT_W-1:0] cnt_t;
  localparam cnt_t CNT_MAX = 6'd63;

  // configuration register indexes
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_SYNC_FRAMES   = 3'd0;
  localparam cfg_idx_t CFG_UNSYNC_FRAMES = 3'd1;
  localparam cfg_idx_t CFG_TRIG_LOW      = 3'd2;
  localparam cfg_idx_t CFG_TRIG_HIGH     = 3'd3;
  localparam cfg_idx_t CFG_TRIG_LEN      = 3'd4;

  localparam int TLEN_W = 5;
  typedef logic [TLEN_W-1:0] tlen_t;

  localparam cnt_t  SYNC_FRAMES_RST   = 6'd50;
  localparam cnt_t  UNSYNC_FRAMES_RST = 6'd25;
  localparam tlen_t TRIG_LEN_RST      = 5'd10;

endpackage

// File: hw/rtl/bstc_trigger_match.sv
// ---------------------------------------------------------------------------
// bstc_trigger_match
// parallel compare of the newest history bytes against the trigger string
// ---------------------------------------------------------------------------
module bstc_trigger_match import bstc_pkg::*; #(
  parameter int TRIGGER_MAX = 16,
  parameter int SEG_W       = 7,
  parameter int LEN_W       = 5
) (
  input  char_t [TRIGGER_MAX-1:0] hist,      // newest byte at index 0
  input  logic  [SEG_W-1:0]       seg_count, // bytes in segment incl. newest
  input  logic  [LEN_W-1:0]       eff_len,   // clamped trigger length
  input  logic  [TRIG_WORD_W-1:0] trig_low,
  input  logic  [TRIG_WORD_W-1:0] trig_high,
  output logic                    match
);

  localparam int IDX_W = (TRIGGER_MAX > 1) ? $clog2(TRIGGER_MAX) : 1;
  localparam int CMP_W = ((SEG_W > LEN_W) ? SEG_W : LEN_W) + 1;

  char_t trig [TRIGGER_MAX];

  // characters past the register words read as zero
  for (genvar k = 0; k < TRIGGER_MAX; k++) begin : g_trig
    if (k < TRIG_WORD_CHARS) begin : g_low
      assign trig[k] = trig_low[k*CHAR_W +: CHAR_W];
    end else if (k < TRIG_REG_CHARS) begin : g_high
      assign trig[k] = trig_high[(k-TRIG_WORD_CHARS)*CHAR_W +: CHAR_W];
    end else begin : g_zero
      assign trig[k] = '0;
    end
  end

  logic             all_eq;
  logic [LEN_W-1:0] idx_full;
  logic [IDX_W-1:0] idx;

  // history byte j pairs with trigger char len-1-j
  always_comb begin
    all_eq   = 1'b1;
    idx_full = '0;
    idx      = '0;
    for (int j = 0; j < TRIGGER_MAX; j++) begin
      if (LEN_W'(j) < eff_len) begin
        idx_full = eff_len - LEN_W'(1) - LEN_W'(j);
        idx      = idx_full[IDX_W-1:0];
        if (hist[j] != trig[idx]) begin
          all_eq = 1'b0;
        end
      end
    end
  end

  assign match = all_eq && (CMP_W'(seg_count) >= CMP_W'(eff_len));

endmodule

// File: hw/rtl/beacon_sync_trigger_controller_core.sv
// an accepted item goes to the input register, then its result to the result register that drives out_tvalid
// throughput: one item per cycle, limited only by the output register handshake
// one input register and one result register; all work is a single combinational pass
// reset (rst_n low, synchronous): mode idle, counters and history zero, not armed,
// ptt low, config registers back to 50 / 25 / zero trigger / length 10
// ---------------------------------------------------------------------------
// beacon_sync_trigger_controller_core
// sync-qualified beacon mode controller with text trigger matching
// ---------------------------------------------------------------------------
`include "beacon_sync_trigger_controller_core_macros.svh"

module beacon_sync_trigger_controller_core import bstc_pkg::*; #(
  parameter int TRIGGER_MAX = 16,
  parameter int LINE_CHARS  = 80
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // input item channel
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [15:0]           in_tdata,   // [0] sync_seen, [1] play_done, [9:2] rx_char
  input  logic                  in_tuser,   // [0] opcode (0 frame tick, 1 character)
  // result channel
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [15:0]           out_tdata   // [2:0] mode, [3] ptt, [4] armed,
                                            // [5] record_start, [6] record_stop,
                                            // [7] clear_totals, [8] reply_start
);

  localparam int SEG_W    = $clog2(LINE_CHARS);
  localparam int LEN_W    = $clog2(TRIGGER_MAX + 1);
  localparam int TLCMP_W  = ((LEN_W > TLEN_W) ? LEN_W : TLEN_W) + 1;
  localparam logic [SEG_W-1:0] SEG_LAST = SEG_W'(LINE_CHARS - 1);

  // ---------------- configuration registers ----------------
  cnt_t                   sync_frames_r, unsync_frames_r;
  logic [TRIG_WORD_W-1:0] trig_low_r, trig_high_r;
  tlen_t                  trig_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_frames_r   <= SYNC_FRAMES_RST;
      unsync_frames_r <= UNSYNC_FRAMES_RST;
      trig_low_r      <= '0;
      trig_high_r     <= '0;
      trig_len_r      <= TRIG_LEN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SYNC_FRAMES:   sync_frames_r   <= cfg_wdata[CNT_W-1:0];
        CFG_UNSYNC_FRAMES: unsync_frames_r <= cfg_wdata[CNT_W-1:0];
        CFG_TRIG_LOW:      trig_low_r      <= cfg_wdata[TRIG_WORD_W-1:0];
        CFG_TRIG_HIGH:     trig_high_r     <= cfg_wdata[TRIG_WORD_W-1:0];
        CFG_TRIG_LEN:      trig_len_r      <= cfg_wdata[TLEN_W-1:0];
        default: ;  // unknown index, ignored
      endcase
    end
  end

  // trigger length clamped to the history depth
  logic [LEN_W-1:0] eff_len;
  assign eff_len = (TLCMP_W'(trig_len_r) > TLCMP_W'(TRIGGER_MAX)) ?
                   LEN_W'(TRIGGER_MAX) : LEN_W'(trig_len_r);

  // ---------------- input register ----------------
  logic  in_valid_r;
  logic  opcode_r, sync_seen_r, play_done_r;
  char_t rx_char_r;
  logic  out_valid_r;
  logic  go;

  // the result register moves when it is empty or being drained
  assign go        = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      opcode_r    <= in_tuser;
      sync_seen_r <= in_tdata[0];
      play_done_r <= in_tdata[1];
      rx_char_r   <= in_tdata[9:2];
    end
  end

  // ---------------- controller state ----------------
  mode_t                   mode_r, mode_nxt;
  cnt_t                    fcnt_r, fcnt_nxt;
  char_t [TRIGGER_MAX-1:0] hist_r, hist_nxt;
  logic [SEG_W-1:0]        seg_r, seg_nxt;
  logic                    match_r, match_nxt;
  logic                    armed_r, armed_nxt;
  logic                    ptt_r, ptt_nxt;
  logic                    rs, rp, ct, rt;

  // character path: wrap on a full segment, push, then test for a match
  logic                    wrap, is_cr, push;
  char_t [TRIGGER_MAX-1:0] hist_base, hist_push;
  logic [SEG_W-1:0]        seg_base, seg_push;
  logic                    match_base, match_hit, match_push;

  assign wrap       = seg_r >= SEG_LAST;
  assign is_cr      = rx_char_r == CH_CR;
  assign push       = !wrap || is_cr;
  assign hist_base  = wrap ? '0 : hist_r;
  assign seg_base   = wrap ? '0 : seg_r;
  assign match_base = wrap ? 1'b0 : match_r;

  always_comb begin
    hist_push = hist_base;
    for (int i = TRIGGER_MAX - 1; i > 0; i--) begin
      hist_push[i] = hist_base[i-1];
    end
    hist_push[0] = rx_char_r;
  end

  assign seg_push = (seg_base < SEG_LAST) ? seg_base + SEG_W'(1) : seg_base;

  bstc_trigger_match #(
    .TRIGGER_MAX (TRIGGER_MAX),
    .SEG_W       (SEG_W),
    .LEN_W       (LEN_W)
  ) u_match (
    .hist      (hist_push),
    .seg_count (seg_push),
    .eff_len   (eff_len),
    .trig_low  (trig_low_r),
    .trig_high (trig_high_r),
    .match     (match_hit)
  );

  assign match_push = match_base || match_hit;

  // saturating increment of the frame counter
  cnt_t fcnt_bump;
  assign fcnt_bump = (fcnt_r < CNT_MAX) ? fcnt_r + CNT_W'(1) : CNT_MAX;

  always_comb begin
    mode_nxt  = mode_r;
    fcnt_nxt  = fcnt_r;
    hist_nxt  = hist_r;
    seg_nxt   = seg_r;
    match_nxt = match_r;
    armed_nxt = armed_r;
    ptt_nxt   = ptt_r;
    rs        = 1'b0;
    rp        = 1'b0;
    ct        = 1'b0;
    rt        = 1'b0;
    if (!opcode_r) begin
      // frame tick
      unique case (mode_r)
        M_IDLE: begin
          if (sync_seen_r) begin
            mode_nxt  = M_MAYBE_SYNC;
            fcnt_nxt  = '0;
            hist_nxt  = '0;
            seg_nxt   = '0;
            match_nxt = 1'b0;
            armed_nxt = 1'b0;
            ct        = 1'b1;
          end
        end
        M_MAYBE_SYNC: begin
          if (sync_seen_r) begin
            fcnt_nxt = fcnt_bump;
            if (fcnt_bump >= sync_frames_r) begin
              mode_nxt = M_SYNC;
              rs       = 1'b1;
            end
          end else begin
            mode_nxt = M_IDLE;
          end
        end
        M_SYNC: begin
          if (sync_seen_r) begin
            fcnt_nxt = fcnt_bump;
          end else begin
            fcnt_nxt = '0;
            mode_nxt = M_MAYBE_UNSYNC;
          end
        end
        M_MAYBE_UNSYNC: begin
          if (!sync_seen_r) begin
            fcnt_nxt = fcnt_bump;
            if (fcnt_bump >= unsync_frames_r) begin
              rp = 1'b1;
              if (armed_r) begin
                mode_nxt = M_TX;
                ptt_nxt  = 1'b1;
                rt       = 1'b1;
              end else begin
                mode_nxt = M_IDLE;
              end
            end
          end else begin
            // false alarm, back to sync
            mode_nxt = M_SYNC;
          end
        end
        default: begin
          // transmit: hold ptt until playback is done
          if (play_done_r) begin
            ptt_nxt  = 1'b0;
            mode_nxt = M_IDLE;
          end
        end
      endcase
    end else begin
      // received character
      if (is_cr) begin
        if (match_push || (eff_len == '0)) begin
          armed_nxt = 1'b1;
        end
        hist_nxt  = '0;
        seg_nxt   = '0;
        match_nxt = 1'b0;
      end else if (push) begin
        hist_nxt  = hist_push;
        seg_nxt   = seg_push;
        match_nxt = match_push;
      end else begin
        // full segment: start over and drop the byte
        hist_nxt  = '0;
        seg_nxt   = '0;
        match_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= M_IDLE;
      fcnt_r  <= '0;
      hist_r  <= '0;
      seg_r   <= '0;
      match_r <= 1'b0;
      armed_r <= 1'b0;
      ptt_r   <= 1'b0;
    end else if (go) begin
      mode_r  <= mode_nxt;
      fcnt_r  <= fcnt_nxt;
      hist_r  <= hist_nxt;
      seg_r   <= seg_nxt;
      match_r <= match_nxt;
      armed_r <= armed_nxt;
      ptt_r   <= ptt_nxt;
    end
  end

  // ---------------- result register ----------------
  logic [15:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (go) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_data_r <= {7'b0, rt, ct, rp, rs, armed_nxt, ptt_nxt, mode_nxt};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // ---------------- assertions ----------------
  // ptt is high exactly while transmitting
  `BSTC_ASSERT_NOW(a_ptt_tx, clk, rst_n, 1'b1, ptt_r == (mode_r == M_TX))
  // a reply only starts together with a confirmed loss while armed
  `BSTC_ASSERT_NOW(a_reply_stop, clk, rst_n, out_valid_r && out_data_r[8],
                   out_data_r[6] && out_data_r[4] && (out_data_r[2:0] == M_TX))
  // sync onset and sync confirmation never come from the same tick
  `BSTC_ASSERT_NOW(a_start_onset, clk, rst_n, out_valid_r && out_data_r[7], !out_data_r[5])
  // the input side only stalls behind a held result
  `BSTC_ASSERT_NOW(a_stall_cause, clk, rst_n, !in_tready, out_valid_r && !out_tready)
  // the segment count stays within the line
  `BSTC_ASSERT_NEXT(a_seg_bound, clk, rst_n, 1'b1, seg_r <= SEG_LAST)

endmodule
